// ===== rtl/hrps_pkg.sv =====
`timescale 1ns / 1ps

package hrps_pkg;

    // Key fields in one report and modifier keys that make events
    localparam int KEY_FIELDS = 6;
    localparam int MOD_STEPS  = 6;

    // Result status codes
    typedef enum logic [1:0] {
        ST_EVENT,
        ST_NO_CHANGE,
        ST_OVERFLOW
    } status_t;

    // Kind of entry handed from the front to the back
    typedef enum logic [1:0] {
        KIND_MOD,
        KIND_KEY,
        KIND_NO_CHANGE,
        KIND_OVERFLOW
    } kind_t;

    // One keyboard report (request)
    typedef struct packed {
        logic [7:0] modifiers;
        logic [2:0] slot_count;
        logic [7:0] key0;
        logic [7:0] key1;
        logic [7:0] key2;
        logic [7:0] key3;
        logic [7:0] key4;
        logic [7:0] key5;
    } report_t;

    // One translated event
    typedef struct packed {
        status_t    status;
        logic [7:0] scan_code;
        logic       extended;
        logic       release_res;
        logic       last;
    } result_t;

    // Classified event: sel is the modifier step or the HID usage code
    typedef struct packed {
        kind_t      kind;
        logic [7:0] sel;
        logic       rel;
    } entry_t;

    // Front to queue control
    typedef struct packed {
        logic   push;
        logic   commit;
        logic   rollback;
        entry_t entry;
    } q_ctl_t;

    // Queue space seen by the front
    typedef struct packed {
        logic room_all;
        logic room_cmt;
    } q_room_t;

    // Queue head seen by the back
    typedef struct packed {
        logic   valid;
        entry_t entry;
        logic   last;
    } q_head_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] code;
        logic       ext;
    } keymap_t;

    typedef struct packed {
        logic [2:0] pos;
        logic [7:0] code;
        logic       ext;
    } modmap_t;

    // Modifier steps in emission order: LCtrl, LShift, LAlt, RShift, RCtrl, RAlt
    function automatic modmap_t mod_map(input logic [2:0] step);
        modmap_t m;
        case (step)
            3'd0:    m = '{3'd0, 8'h14, 1'b0};
            3'd1:    m = '{3'd1, 8'h12, 1'b0};
            3'd2:    m = '{3'd2, 8'h11, 1'b0};
            3'd3:    m = '{3'd5, 8'h59, 1'b0};
            3'd4:    m = '{3'd4, 8'h14, 1'b1};
            3'd5:    m = '{3'd6, 8'h11, 1'b1};
            default: m = '0;
        endcase
        return m;
    endfunction

    // HID usage code to set-2 scan code; hit low for codes with no mapping
    function automatic keymap_t hid_lookup(input logic [7:0] hid);
        keymap_t r;
        case (hid)
            8'h04: r = '{1'b1, 8'h1C, 1'b0};  8'h05: r = '{1'b1, 8'h32, 1'b0};
            8'h06: r = '{1'b1, 8'h21, 1'b0};  8'h07: r = '{1'b1, 8'h23, 1'b0};
            8'h08: r = '{1'b1, 8'h24, 1'b0};  8'h09: r = '{1'b1, 8'h2B, 1'b0};
            8'h0A: r = '{1'b1, 8'h34, 1'b0};  8'h0B: r = '{1'b1, 8'h33, 1'b0};
            8'h0C: r = '{1'b1, 8'h43, 1'b0};  8'h0D: r = '{1'b1, 8'h3B, 1'b0};
            8'h0E: r = '{1'b1, 8'h42, 1'b0};  8'h0F: r = '{1'b1, 8'h4B, 1'b0};
            8'h10: r = '{1'b1, 8'h3A, 1'b0};  8'h11: r = '{1'b1, 8'h31, 1'b0};
            8'h12: r = '{1'b1, 8'h44, 1'b0};  8'h13: r = '{1'b1, 8'h4D, 1'b0};
            8'h14: r = '{1'b1, 8'h15, 1'b0};  8'h15: r = '{1'b1, 8'h2D, 1'b0};
            8'h16: r = '{1'b1, 8'h1B, 1'b0};  8'h17: r = '{1'b1, 8'h2C, 1'b0};
            8'h18: r = '{1'b1, 8'h3C, 1'b0};  8'h19: r = '{1'b1, 8'h2A, 1'b0};
            8'h1A: r = '{1'b1, 8'h1D, 1'b0};  8'h1B: r = '{1'b1, 8'h22, 1'b0};
            8'h1C: r = '{1'b1, 8'h35, 1'b0};  8'h1D: r = '{1'b1, 8'h1A, 1'b0};
            8'h1E: r = '{1'b1, 8'h16, 1'b0};  8'h1F: r = '{1'b1, 8'h1E, 1'b0};
            8'h20: r = '{1'b1, 8'h26, 1'b0};  8'h21: r = '{1'b1, 8'h25, 1'b0};
            8'h22: r = '{1'b1, 8'h2E, 1'b0};  8'h23: r = '{1'b1, 8'h36, 1'b0};
            8'h24: r = '{1'b1, 8'h3D, 1'b0};  8'h25: r = '{1'b1, 8'h3E, 1'b0};
            8'h26: r = '{1'b1, 8'h46, 1'b0};  8'h27: r = '{1'b1, 8'h45, 1'b0};
            8'h28: r = '{1'b1, 8'h5A, 1'b0};  8'h29: r = '{1'b1, 8'h76, 1'b0};
            8'h2A: r = '{1'b1, 8'h66, 1'b0};  8'h2B: r = '{1'b1, 8'h0D, 1'b0};
            8'h2C: r = '{1'b1, 8'h29, 1'b0};
            8'h3A: r = '{1'b1, 8'h05, 1'b0};  8'h3B: r = '{1'b1, 8'h06, 1'b0};
            8'h3C: r = '{1'b1, 8'h04, 1'b0};  8'h3D: r = '{1'b1, 8'h0C, 1'b0};
            8'h3E: r = '{1'b1, 8'h03, 1'b0};  8'h3F: r = '{1'b1, 8'h0B, 1'b0};
            8'h40: r = '{1'b1, 8'h83, 1'b0};  8'h41: r = '{1'b1, 8'h0A, 1'b0};
            8'h42: r = '{1'b1, 8'h01, 1'b0};  8'h43: r = '{1'b1, 8'h09, 1'b0};
            8'h44: r = '{1'b1, 8'h78, 1'b0};  8'h45: r = '{1'b1, 8'h07, 1'b0};
            8'h49: r = '{1'b1, 8'h70, 1'b1};  8'h4A: r = '{1'b1, 8'h6C, 1'b1};
            8'h4B: r = '{1'b1, 8'h7D, 1'b1};  8'h4C: r = '{1'b1, 8'h71, 1'b1};
            8'h4D: r = '{1'b1, 8'h69, 1'b1};  8'h4E: r = '{1'b1, 8'h7A, 1'b1};
            8'h4F: r = '{1'b1, 8'h74, 1'b1};  8'h50: r = '{1'b1, 8'h6B, 1'b1};
            8'h51: r = '{1'b1, 8'h72, 1'b1};  8'h52: r = '{1'b1, 8'h75, 1'b1};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/hid_report_to_ps2_scancodes.sv =====
`timescale 1ns / 1ps
// A report is walked in the front one modifier or key slot per step, then closed;
// its results pass through the event queue and the output register.
// A new report is taken only once the front is idle again after its slot walk;
// results leave at one per cycle unless stalled, also while the next report is walked.
// Reset (rst_n low, async): stored report cleared to zero, queue and output emptied.

module hid_report_to_ps2_scancodes #(
    parameter int KEY_SLOTS   = 6,
    parameter int EVENT_LIMIT = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              report_valid,
    output logic              report_stall,
    input  hrps_pkg::report_t report,
    output logic              result_valid,
    input  logic              result_stall,
    output hrps_pkg::result_t result
);

    hrps_pkg::q_ctl_t  qctl;
    hrps_pkg::q_room_t qroom;
    hrps_pkg::q_head_t head;
    logic              pop;

    // Report walk and event classification
    hrps_front #(
        .KEY_SLOTS   (KEY_SLOTS),
        .EVENT_LIMIT (EVENT_LIMIT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .report_valid (report_valid),
        .report_stall (report_stall),
        .report       (report),
        .qroom        (qroom),
        .qctl         (qctl)
    );

    // Event queue with commit and rollback
    hrps_queue #(
        .DEPTH (EVENT_LIMIT)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .qctl  (qctl),
        .qroom (qroom),
        .head  (head),
        .pop   (pop)
    );

    // Scan code mapping and output register
    hrps_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== rtl/hrps_front.sv =====
`timescale 1ns / 1ps

module hrps_front #(
    parameter int KEY_SLOTS   = 6,
    parameter int EVENT_LIMIT = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               report_valid,
    output logic               report_stall,
    input  hrps_pkg::report_t  report,
    input  hrps_pkg::q_room_t  qroom,
    output hrps_pkg::q_ctl_t   qctl
);

    localparam int CAP   = (KEY_SLOTS < hrps_pkg::KEY_FIELDS) ? KEY_SLOTS
                                                              : hrps_pkg::KEY_FIELDS;
    localparam int IDX_W = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int N_W   = $clog2(EVENT_LIMIT);
    localparam logic [N_W-1:0] N_LAST = N_W'(EVENT_LIMIT - 1);

    typedef enum logic [2:0] {
        F_IDLE,
        F_MODS,
        F_OLD,
        F_NEW,
        F_FIN
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] idx_reg, idx_next;
    logic [N_W-1:0] n_reg, n_next;
    logic [7:0] mods_reg, mods_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [7:0] keys_reg [hrps_pkg::KEY_FIELDS];
    logic [7:0] keys_next [hrps_pkg::KEY_FIELDS];
    logic [7:0] prev_mods_reg, prev_mods_next;
    logic [2:0] prev_cnt_reg, prev_cnt_next;
    logic [7:0] prev_keys_reg [CAP];
    logic [7:0] prev_keys_next [CAP];

    logic [7:0] keys_in [hrps_pkg::KEY_FIELDS];
    logic [2:0] cnt_sat;

    hrps_pkg::modmap_t mod_cur;
    logic [7:0]        cand;
    hrps_pkg::keymap_t cand_map;
    logic              in_new;
    logic              in_old;
    logic              ev;
    hrps_pkg::entry_t  ev_entry;
    logic [2:0]        limit;
    state_t            after;

    // Unpack the report and clamp the key count
    assign keys_in[0] = report.key0;
    assign keys_in[1] = report.key1;
    assign keys_in[2] = report.key2;
    assign keys_in[3] = report.key3;
    assign keys_in[4] = report.key4;
    assign keys_in[5] = report.key5;
    assign cnt_sat = (report.slot_count > 3'(CAP)) ? 3'(CAP) : report.slot_count;

    assign report_stall = (state_reg != F_IDLE);

    // Candidate key for this step and its presence in the other report
    assign mod_cur = hrps_pkg::mod_map(idx_reg);
    assign cand = (state_reg == F_OLD) ? prev_keys_reg[idx_reg[IDX_W-1:0]]
                                       : keys_reg[idx_reg];
    assign cand_map = hrps_pkg::hid_lookup(cand);

    always_comb
    begin
        in_new = 1'b0;
        in_old = 1'b0;
        for (int j = 0; j < hrps_pkg::KEY_FIELDS; j++)
        begin
            if ((3'(j) < cnt_reg) && (keys_reg[j] == cand))
                in_new = 1'b1;
        end
        for (int j = 0; j < CAP; j++)
        begin
            if ((3'(j) < prev_cnt_reg) && (prev_keys_reg[j] == cand))
                in_old = 1'b1;
        end
    end

    // Classify the current step
    always_comb
    begin
        ev       = 1'b0;
        ev_entry = '0;
        limit    = 3'(hrps_pkg::MOD_STEPS - 1);
        after    = F_FIN;
        case (state_reg)
            F_MODS:
            begin
                ev            = mods_reg[mod_cur.pos] ^ prev_mods_reg[mod_cur.pos];
                ev_entry.kind = hrps_pkg::KIND_MOD;
                ev_entry.sel  = {5'b0, idx_reg};
                ev_entry.rel  = ~mods_reg[mod_cur.pos];
                if (prev_cnt_reg != 3'd0)
                    after = F_OLD;
                else if (cnt_reg != 3'd0)
                    after = F_NEW;
                else
                    after = F_FIN;
            end
            F_OLD:
            begin
                ev            = ~in_new & cand_map.hit;
                ev_entry.kind = hrps_pkg::KIND_KEY;
                ev_entry.sel  = cand;
                ev_entry.rel  = 1'b1;
                limit         = prev_cnt_reg - 3'd1;
                after         = (cnt_reg != 3'd0) ? F_NEW : F_FIN;
            end
            F_NEW:
            begin
                ev            = ~in_old & cand_map.hit;
                ev_entry.kind = hrps_pkg::KIND_KEY;
                ev_entry.sel  = cand;
                ev_entry.rel  = 1'b0;
                limit         = cnt_reg - 3'd1;
                after         = F_FIN;
            end
            default:
            begin
                ev = 1'b0;
            end
        endcase
    end

    // Sequencer: walk modifiers, old slots, new slots, then close the report
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        mods_next      = mods_reg;
        cnt_next       = cnt_reg;
        keys_next      = keys_reg;
        prev_mods_next = prev_mods_reg;
        prev_cnt_next  = prev_cnt_reg;
        prev_keys_next = prev_keys_reg;
        qctl           = '0;
        case (state_reg)
            F_IDLE:
            begin
                if (report_valid)
                begin
                    mods_next  = report.modifiers;
                    cnt_next   = cnt_sat;
                    keys_next  = keys_in;
                    n_next     = '0;
                    idx_next   = 3'd0;
                    state_next = F_MODS;
                end
            end
            F_MODS, F_OLD, F_NEW:
            begin
                if (ev && (n_reg == N_LAST))
                begin
                    // Too many events: drop them and keep the stored report
                    if (qroom.room_cmt)
                    begin
                        qctl.rollback   = 1'b1;
                        qctl.push       = 1'b1;
                        qctl.commit     = 1'b1;
                        qctl.entry.kind = hrps_pkg::KIND_OVERFLOW;
                        state_next      = F_IDLE;
                    end
                end
                else if (!ev || qroom.room_all)
                begin
                    if (ev)
                    begin
                        qctl.push  = 1'b1;
                        qctl.entry = ev_entry;
                        n_next     = n_reg + N_W'(1);
                    end
                    if (idx_reg == limit)
                    begin
                        idx_next   = 3'd0;
                        state_next = after;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            F_FIN:
            begin
                if ((n_reg != '0) || qroom.room_all)
                begin
                    if (n_reg == '0)
                    begin
                        qctl.push       = 1'b1;
                        qctl.entry.kind = hrps_pkg::KIND_NO_CHANGE;
                    end
                    qctl.commit    = 1'b1;
                    prev_mods_next = mods_reg;
                    prev_cnt_next  = cnt_reg;
                    for (int i = 0; i < CAP; i++)
                    begin
                        if (3'(i) < cnt_reg)
                            prev_keys_next[i] = keys_reg[i];
                    end
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            idx_reg       <= '0;
            n_reg         <= '0;
            mods_reg      <= '0;
            cnt_reg       <= '0;
            prev_mods_reg <= '0;
            prev_cnt_reg  <= '0;
            for (int i = 0; i < hrps_pkg::KEY_FIELDS; i++)
                keys_reg[i] <= '0;
            for (int i = 0; i < CAP; i++)
                prev_keys_reg[i] <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            n_reg         <= n_next;
            mods_reg      <= mods_next;
            cnt_reg       <= cnt_next;
            prev_mods_reg <= prev_mods_next;
            prev_cnt_reg  <= prev_cnt_next;
            keys_reg      <= keys_next;
            prev_keys_reg <= prev_keys_next;
        end
    end

    // Checks
    a_rollback_is_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        qctl.rollback |-> (qctl.commit && qctl.push
                           && qctl.entry.kind == hrps_pkg::KIND_OVERFLOW))
        else $error("rollback without overflow commit");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= N_LAST)
        else $error("event count passed the limit");

    a_commit_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        qctl.commit |=> state_reg == F_IDLE)
        else $error("front kept walking after commit");

endmodule

// ===== rtl/hrps_queue.sv =====
`timescale 1ns / 1ps

module hrps_queue #(
    parameter int DEPTH = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  hrps_pkg::q_ctl_t  qctl,
    output hrps_pkg::q_room_t qroom,
    output hrps_pkg::q_head_t head,
    input  logic              pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);

    hrps_pkg::entry_t ent_reg [DEPTH];
    logic [DEPTH-1:0] last_reg;

    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] cmt_wr_reg, cmt_wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_all_reg, cnt_all_next;
    logic [CNT_W-1:0] cnt_cmt_reg, cnt_cmt_next;

    logic [PTR_W-1:0] base_wr;
    logic [PTR_W-1:0] base_prev;
    logic [CNT_W-1:0] all_base;

    // Speculative entries since the last commit are dropped on rollback
    assign base_wr   = qctl.rollback ? cmt_wr_reg : wr_reg;
    assign base_prev = (base_wr == '0) ? PTR_MAX : base_wr - PTR_W'(1);
    assign all_base  = qctl.rollback ? cnt_cmt_reg : cnt_all_reg;

    always_comb
    begin
        wr_next = base_wr;
        if (qctl.push)
            wr_next = (base_wr == PTR_MAX) ? '0 : base_wr + PTR_W'(1);
        rd_next = rd_reg;
        if (pop)
            rd_next = (rd_reg == PTR_MAX) ? '0 : rd_reg + PTR_W'(1);
        cnt_all_next = all_base + CNT_W'(qctl.push) - CNT_W'(pop);
        cnt_cmt_next = qctl.commit ? cnt_all_next : cnt_cmt_reg - CNT_W'(pop);
        cmt_wr_next  = qctl.commit ? wr_next : cmt_wr_reg;
    end

    // Pointers and counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg      <= '0;
            cmt_wr_reg  <= '0;
            rd_reg      <= '0;
            cnt_all_reg <= '0;
            cnt_cmt_reg <= '0;
        end
        else
        begin
            wr_reg      <= wr_next;
            cmt_wr_reg  <= cmt_wr_next;
            rd_reg      <= rd_next;
            cnt_all_reg <= cnt_all_next;
            cnt_cmt_reg <= cnt_cmt_next;
        end
    end

    // Entry storage; the last mark goes on the newest entry at commit
    always_ff @(posedge clk)
    begin
        if (qctl.push)
        begin
            ent_reg[base_wr]  <= qctl.entry;
            last_reg[base_wr] <= qctl.commit;
        end
        else if (qctl.commit)
        begin
            last_reg[base_prev] <= 1'b1;
        end
    end

    assign qroom.room_all = (cnt_all_reg != CNT_W'(DEPTH));
    assign qroom.room_cmt = (cnt_cmt_reg != CNT_W'(DEPTH));
    assign head.valid     = (cnt_cmt_reg != '0);
    assign head.entry     = ent_reg[rd_reg];
    assign head.last      = last_reg[rd_reg];

    // Checks
    a_cmt_within_all: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_cmt_reg <= cnt_all_reg)
        else $error("committed count exceeds stored count");

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        qctl.push |-> (all_base != CNT_W'(DEPTH)) || pop)
        else $error("push into a full queue");

endmodule

// ===== rtl/hrps_back.sv =====
`timescale 1ns / 1ps

module hrps_back (
    input  logic              clk,
    input  logic              rst_n,
    input  hrps_pkg::q_head_t head,
    output logic              pop,
    output logic              result_valid,
    input  logic              result_stall,
    output hrps_pkg::result_t result
);

    logic              valid_reg, valid_next;
    hrps_pkg::result_t res_reg, res_next;
    hrps_pkg::result_t mapped;
    hrps_pkg::keymap_t key_map;
    hrps_pkg::modmap_t mod_cur;

    assign key_map = hrps_pkg::hid_lookup(head.entry.sel);
    assign mod_cur = hrps_pkg::mod_map(head.entry.sel[2:0]);

    // Turn a queued entry into scan code fields
    always_comb
    begin
        mapped      = '0;
        mapped.last = head.last;
        case (head.entry.kind)
            hrps_pkg::KIND_MOD:
            begin
                mapped.status      = hrps_pkg::ST_EVENT;
                mapped.scan_code   = mod_cur.code;
                mapped.extended    = mod_cur.ext;
                mapped.release_res = head.entry.rel;
            end
            hrps_pkg::KIND_KEY:
            begin
                mapped.status      = hrps_pkg::ST_EVENT;
                mapped.scan_code   = key_map.code;
                mapped.extended    = key_map.ext;
                mapped.release_res = head.entry.rel;
            end
            hrps_pkg::KIND_NO_CHANGE:
            begin
                mapped.status = hrps_pkg::ST_NO_CHANGE;
            end
            hrps_pkg::KIND_OVERFLOW:
            begin
                mapped.status = hrps_pkg::ST_OVERFLOW;
            end
            default:
            begin
                mapped.status = hrps_pkg::ST_EVENT;
            end
        endcase
    end

    // Output register, refilled in the cycle it empties
    assign pop = head.valid && (!valid_reg || !result_stall);

    always_comb
    begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (pop)
        begin
            valid_next = 1'b1;
            res_next   = mapped;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            res_reg   <= res_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = res_reg;

    // Checks
    a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status != hrps_pkg::ST_EVENT)) |-> result.last)
        else $error("no-change or overflow result without last mark");

endmodule
